FILE: rtl/bfvm_pkg.sv
// ----------------------------------------------------------------------------
// bfvm_pkg
// Shared types, constants and helpers for the block-float vector multiplier.
// ----------------------------------------------------------------------------
package bfvm_pkg;

    typedef logic signed [31:0] word_t;
    typedef logic signed [6:0]  shamt_t;
    typedef logic signed [63:0] dword_t;
    typedef logic [4:0]         hroom_t;

    // Configuration register indexes (byte address is four times the index).
    localparam int unsigned REG_B_SHIFT = 0;
    localparam int unsigned REG_C_SHIFT = 1;

    localparam hroom_t HR_START = 5'd31;

    // Prescale saturation limits (full signed 32-bit range).
    localparam word_t S32_MAX = 32'sh7FFF_FFFF;
    localparam word_t S32_MIN = 32'sh8000_0000;

    // Product rounding and symmetric saturation.
    localparam dword_t              ROUND_ADD = 64'sh0000_0000_2000_0000;
    localparam int unsigned         PROD_SHIFT = 30;
    localparam logic signed [33:0]  RND_MAX = 34'sh0_7FFF_FFFF;
    localparam logic signed [33:0]  RND_MIN = -34'sh0_7FFF_FFFF;
    localparam word_t               PROD_MAX = 32'sh7FFF_FFFF;
    localparam word_t               PROD_MIN = 32'sh8000_0001;

    // Leading zero count of a 32-bit word by a five-step binary search.
    function automatic hroom_t lead_zeros(input logic [31:0] x);
        logic [31:0] y;
        hroom_t      n;
        y = x;
        n = '0;
        if (y[31:16] == 16'h0)
        begin
            n[4] = 1'b1;
            y    = {y[15:0], 16'h0};
        end
        if (y[31:24] == 8'h0)
        begin
            n[3] = 1'b1;
            y    = {y[23:0], 8'h0};
        end
        if (y[31:28] == 4'h0)
        begin
            n[2] = 1'b1;
            y    = {y[27:0], 4'h0};
        end
        if (y[31:30] == 2'h0)
        begin
            n[1] = 1'b1;
            y    = {y[29:0], 2'h0};
        end
        if (!y[31])
        begin
            n[0] = 1'b1;
        end
        return n;
    endfunction

    // Redundant sign bits of a word; zero and minus one both give 31.
    function automatic hroom_t headroom(input word_t p);
        return lead_zeros({p[30:0] ^ {31{p[31]}}, 1'b1});
    endfunction

endpackage

FILE: rtl/bfvm_prescale.sv
// ----------------------------------------------------------------------------
// bfvm_prescale
// Arithmetic shift of one element by a signed amount, saturating on left shift.
// ----------------------------------------------------------------------------
module bfvm_prescale (
    input  bfvm_pkg::word_t  value,
    input  bfvm_pkg::shamt_t shift,
    output bfvm_pkg::word_t  result
);
    import bfvm_pkg::*;

    logic [6:0]         left_amt;
    logic signed [63:0] wide;
    logic               fits;

    assign left_amt = 7'(-shift);
    assign wide     = 64'(value) <<< left_amt[4:0];
    assign fits     = (wide[63:31] == '0) || (wide[63:31] == '1);

    always_comb
    begin
        priority if (!shift[6])
        begin
            // Right shift; 32 or more leaves only the sign.
            if (shift[5])
                result = {32{value[31]}};
            else
                result = value >>> shift[4:0];
        end
        else if (value == '0)
        begin
            result = '0;
        end
        else if (left_amt[6] || left_amt[5] || !fits)
        begin
            result = value[31] ? S32_MIN : S32_MAX;
        end
        else
        begin
            result = wide[31:0];
        end
    end

endmodule

FILE: rtl/bfvm_round_sat.sv
// ----------------------------------------------------------------------------
// bfvm_round_sat
// Rounds the Q60 product to Q30, saturates symmetrically and measures headroom.
// ----------------------------------------------------------------------------
module bfvm_round_sat (
    input  bfvm_pkg::dword_t prod,
    output bfvm_pkg::word_t  result,
    output bfvm_pkg::hroom_t hroom
);
    import bfvm_pkg::*;

    dword_t             sum;
    logic signed [33:0] scaled;

    // The product never exceeds 2^62, so adding the rounding constant cannot wrap.
    assign sum    = prod + ROUND_ADD;
    assign scaled = sum[63:PROD_SHIFT];

    always_comb
    begin
        priority if (scaled > RND_MAX)
            result = PROD_MAX;
        else if (scaled < RND_MIN)
            result = PROD_MIN;
        else
            result = scaled[31:0];
    end

    assign hroom = headroom(result);

endmodule

FILE: rtl/block_float_vector_multiply_s32.sv
// ----------------------------------------------------------------------------
// block_float_vector_multiply_s32
// Element-wise Q30 multiply of two prescaled streams with running headroom.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake               Payload
//  -------   ---------------------   ------------------------------------
//  elem      elem_valid/elem_stall   b_value, c_value, last_in
//  prod      prod_valid/prod_stall   product, min_headroom, last_out
//  config    APB (psel, penable..)   b_shift at 0x0, c_shift at 0x4
//
// One beat is accepted every clock cycle while the result side keeps taking
// beats. A beat passes through four register stages (input, prescale,
// multiply, output) in that order, and the single 32x32 multiplier stage
// sets the throughput of one beat a cycle while no stall holds the pipe.
// Reset clears every stage valid bit, both shift registers and the running
// headroom (to 31). A stall on the result side only backs up stages that are
// full, so empty stages keep absorbing beats until the whole pipe is occupied.
//
module block_float_vector_multiply_s32 (
    input  logic             clk,
    input  logic             rst_n,

    input  logic             elem_valid,
    output logic             elem_stall,
    input  bfvm_pkg::word_t  b_value,
    input  bfvm_pkg::word_t  c_value,
    input  logic             last_in,

    output logic             prod_valid,
    input  logic             prod_stall,
    output bfvm_pkg::word_t  product,
    output bfvm_pkg::hroom_t min_headroom,
    output logic             last_out,

    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import bfvm_pkg::*;

    // Configuration registers. The register index is the word address bit.
    shamt_t b_shift_reg;
    shamt_t c_shift_reg;
    logic   cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_shift_reg <= '0;
            c_shift_reg <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == 1'(REG_B_SHIFT))
                b_shift_reg <= pwdata[6:0];
            else
                c_shift_reg <= pwdata[6:0];
        end
    end

    assign prdata = (paddr[2] == 1'(REG_B_SHIFT)) ? {25'h0, b_shift_reg}
                                                   : {25'h0, c_shift_reg};

    // Stage enables: a stage loads when it is empty or its contents move on.
    logic out_en;
    logic mul_en;
    logic pre_en;
    logic in_en;

    logic   in_v_reg;
    word_t  in_b_reg;
    word_t  in_c_reg;
    logic   in_last_reg;

    logic   pre_v_reg;
    word_t  pre_b_reg;
    word_t  pre_c_reg;
    logic   pre_last_reg;

    logic   mul_v_reg;
    dword_t mul_p_reg;
    logic   mul_last_reg;

    logic   out_v_reg;
    word_t  out_p_reg;
    hroom_t out_hr_reg;
    logic   out_last_reg;

    hroom_t run_hr_reg;
    hroom_t run_hr_next;

    word_t  b_pre;
    word_t  c_pre;
    word_t  rnd_p;
    hroom_t rnd_hr;
    hroom_t min_hr;

    assign out_en = !out_v_reg || !prod_stall;
    assign mul_en = !mul_v_reg || out_en;
    assign pre_en = !pre_v_reg || mul_en;
    assign in_en  = !in_v_reg || pre_en;

    assign elem_stall = !in_en;

    // Input stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_v_reg <= 1'b0;
        else if (in_en)
            in_v_reg <= elem_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_en && elem_valid)
        begin
            in_b_reg    <= b_value;
            in_c_reg    <= c_value;
            in_last_reg <= last_in;
        end
    end

    // Prescale stage.
    bfvm_prescale u_pre_b (
        .value  (in_b_reg),
        .shift  (b_shift_reg),
        .result (b_pre)
    );

    bfvm_prescale u_pre_c (
        .value  (in_c_reg),
        .shift  (c_shift_reg),
        .result (c_pre)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pre_v_reg <= 1'b0;
        else if (pre_en)
            pre_v_reg <= in_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pre_en && in_v_reg)
        begin
            pre_b_reg    <= b_pre;
            pre_c_reg    <= c_pre;
            pre_last_reg <= in_last_reg;
        end
    end

    // Multiply stage: exact 64-bit signed product.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_v_reg <= 1'b0;
        else if (mul_en)
            mul_v_reg <= pre_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mul_en && pre_v_reg)
        begin
            mul_p_reg    <= 64'(pre_b_reg) * 64'(pre_c_reg);
            mul_last_reg <= pre_last_reg;
        end
    end

    // Output stage: rounding, saturation and the running minimum headroom.
    bfvm_round_sat u_rnd (
        .prod   (mul_p_reg),
        .result (rnd_p),
        .hroom  (rnd_hr)
    );

    assign min_hr      = (rnd_hr < run_hr_reg) ? rnd_hr : run_hr_reg;
    assign run_hr_next = mul_last_reg ? HR_START : min_hr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            run_hr_reg <= HR_START;
        end
        else if (out_en)
        begin
            out_v_reg <= mul_v_reg;
            if (mul_v_reg)
                run_hr_reg <= run_hr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en && mul_v_reg)
        begin
            out_p_reg    <= rnd_p;
            out_hr_reg   <= min_hr;
            out_last_reg <= mul_last_reg;
        end
    end

    assign prod_valid   = out_v_reg;
    assign product      = out_p_reg;
    assign min_headroom = out_hr_reg;
    assign last_out     = out_last_reg;

`ifndef SYNTHESIS
    // Symmetric saturation never yields the most negative word.
    a_no_min_word: assert property (@(posedge clk) disable iff (!rst_n)
        prod_valid |-> (product != S32_MIN))
        else $error("product holds the most negative word");

    // The reported minimum never exceeds the headroom of its own product.
    a_min_bound: assert property (@(posedge clk) disable iff (!rst_n)
        prod_valid |-> (min_headroom <= headroom(product)))
        else $error("min_headroom above the product's headroom");

    // Loading the final beat of a vector restarts the running headroom.
    a_hr_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (out_en && mul_v_reg && mul_last_reg) |=> (run_hr_reg == HR_START))
        else $error("running headroom not restarted after last beat");

    // A stalled multiply stage keeps its beat: its valid data is not dropped.
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (mul_v_reg && !out_en) |=> mul_v_reg)
        else $error("multiply stage beat lost while stalled");
`endif

endmodule
